// ===== sv/ccct_pkg.sv =====
package ccct_pkg;

   // table geometry
   localparam int POSITIONS   = 4096;
   localparam int KINDS       = 4;
   localparam int COUNT_WIDTH = 16;

   localparam int DEPTH  = POSITIONS * KINDS;
   localparam int ADDR_W = $clog2(DEPTH);

   // word field widths
   localparam int OP_W       = 2;
   localparam int POSITION_W = 12;
   localparam int KIND_W     = 2;
   localparam int SPAN_W     = 13;
   localparam int AMOUNT_W   = 16;
   localparam int CAP_W      = 16;
   localparam int RCOUNT_W   = 16;

   // walk pointer holds position + span without wrapping
   localparam int WALK_W = ((POSITION_W > SPAN_W) ? POSITION_W : SPAN_W) + 1;
   // sums and cap compares are done one bit wider than either operand
   localparam int SUM_W  = ((COUNT_WIDTH > AMOUNT_W) ? COUNT_WIDTH : AMOUNT_W) + 1;

   localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'((64'd1 << COUNT_WIDTH) - 64'd1);

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_SET   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;
   localparam logic [OP_W-1:0] OP_TOXIC = 2'd3;

   typedef struct packed {
      logic                   rd_en;
      logic                   wr_en;
      logic [ADDR_W-1:0]      addr;
      logic [COUNT_WIDTH-1:0] wdata;
   } mem_req_type;

endpackage

// ===== sv/ccct_if.sv =====
interface ccct_req_if;
   import ccct_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       op;
   logic [POSITION_W-1:0] position;
   logic [KIND_W-1:0]     kind;
   logic [SPAN_W-1:0]     span;
   logic [AMOUNT_W-1:0]   amount;

   modport source (output valid, op, position, kind, span, amount, input ready);
   modport sink   (input valid, op, position, kind, span, amount, output ready);
endinterface

interface ccct_rsp_if;
   import ccct_pkg::*;
   logic                valid;
   logic                ready;
   logic [RCOUNT_W-1:0] count;
   logic                toxic;
   logic                out_of_range;

   modport source (output valid, count, toxic, out_of_range, input ready);
   modport sink   (input valid, count, toxic, out_of_range, output ready);
endinterface

interface ccct_csr_if;
   import ccct_pkg::*;
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== sv/capped_coverage_count_table.sv =====
// Steps: a set writes its entry directly; a read reads its entry and keeps the value;
//   a toxic check reads its three probes in turn, counting probes past the end as uncapped;
//   an add reads and writes back each position in turn and stops at the first one past the end.
// Throughput: one word at a time; the next word is taken once the result is registered.
//   Adds read then write back each entry through the single table port; others only read or write.
// Reset: synchronous, active high; the cap returns to 65535 and the table is zeroed
//   by a sweep over all 16384 entries, during which no word is taken (cap writes still are).
module capped_coverage_count_table (
   input  logic       clock,
   input  logic       reset,
   ccct_req_if.sink   req_bus,
   ccct_rsp_if.source rsp_bus,
   ccct_csr_if.sink   csr_bus
);
   import ccct_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_READ   = 2'd1;
   localparam logic [1:0] S_MODIFY = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [POSITION_W-1:0] pos_ff, pos_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [SPAN_W-1:0]     span_ff, span_in;
   logic [AMOUNT_W-1:0]   amount_ff, amount_in;
   logic [WALK_W-1:0]     ptr_ff, ptr_in;
   logic [SPAN_W-1:0]     remain_ff, remain_in;
   logic [1:0]            probe_ff, probe_in;
   logic                  oor_ff, oor_in;
   logic                  all_ff, all_in;
   logic [RCOUNT_W-1:0]   count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RCOUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                  rsp_toxic_ff, rsp_toxic_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   logic [CAP_W-1:0]      cap_ff, cap_in;

   mem_req_type            mem_req;
   logic [COUNT_WIDTH-1:0] rdata;
   logic                   clr_busy;

   logic [SUM_W-1:0]  cap_eff;
   logic [SUM_W-1:0]  sum;
   logic [ADDR_W-1:0] addr_cur;
   logic              ptr_in_table;
   logic [WALK_W-1:0] probe_mid;
   logic [WALK_W-1:0] probe_end;
   logic              req_take;
   logic              slot_free;

   ccct_store u_store (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (mem_req),
      .rdata_ff (rdata),
      .busy     (clr_busy)
   );

   assign csr_bus.ready = 1'b1;
   assign cap_in = (csr_bus.valid) ? csr_bus.data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '1;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign cap_eff      = (SUM_W'(cap_ff) > COUNT_MAX) ? COUNT_MAX : SUM_W'(cap_ff);
   assign sum          = SUM_W'(rdata) + SUM_W'(amount_ff);
   assign ptr_in_table = 32'(ptr_ff) < POSITIONS;
   assign addr_cur     = ADDR_W'(ptr_ff) * ADDR_W'(KINDS) + ADDR_W'(kind_ff);
   assign probe_mid    = WALK_W'(pos_ff) + WALK_W'(span_ff >> 1);
   assign probe_end    = WALK_W'(pos_ff) + WALK_W'(span_ff);

   assign req_bus.ready = (state_ff == S_IDLE) && !clr_busy;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      kind_in      = kind_ff;
      span_in      = span_ff;
      amount_in    = amount_ff;
      ptr_in       = ptr_ff;
      remain_in    = remain_ff;
      probe_in     = probe_ff;
      oor_in       = oor_ff;
      all_in       = all_ff;
      count_in     = count_ff;
      rsp_count_in = rsp_count_ff;
      rsp_toxic_in = rsp_toxic_ff;
      rsp_oor_in   = rsp_oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      mem_req      = '0;
      mem_req.addr = addr_cur;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in     = req_bus.op;
               pos_in    = req_bus.position;
               kind_in   = req_bus.kind;
               span_in   = req_bus.span;
               amount_in = req_bus.amount;
               ptr_in    = WALK_W'(req_bus.position);
               remain_in = req_bus.span;
               probe_in  = '0;
               count_in  = '0;
               if (32'(req_bus.kind) >= KINDS) begin
                  oor_in   = 1'b1;
                  all_in   = 1'b0;
                  state_in = S_DONE;
               end else begin
                  oor_in   = 1'b0;
                  all_in   = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            case (op_ff)
               OP_ADD: begin
                  if (remain_ff == '0) begin
                     state_in = S_DONE;
                  end else if (!ptr_in_table) begin
                     // rest of the run lies past the end: flag and drop it
                     oor_in   = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     mem_req.rd_en = 1'b1;
                     state_in      = S_MODIFY;
                  end
               end
               OP_SET: begin
                  if (!ptr_in_table) begin
                     oor_in = 1'b1;
                  end else if (SUM_W'(amount_ff) <= cap_eff) begin
                     mem_req.wr_en = 1'b1;
                     mem_req.wdata = COUNT_WIDTH'(amount_ff);
                  end
                  state_in = S_DONE;
               end
               OP_READ: begin
                  if (!ptr_in_table) begin
                     oor_in   = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     mem_req.rd_en = 1'b1;
                     state_in      = S_MODIFY;
                  end
               end
               default: begin
                  if (ptr_in_table) begin
                     mem_req.rd_en = 1'b1;
                     state_in      = S_MODIFY;
                  end else begin
                     oor_in = 1'b1;
                     all_in = 1'b0;
                     if (probe_ff == 2'd2) begin
                        state_in = S_DONE;
                     end else begin
                        probe_in = probe_ff + 1'b1;
                        ptr_in   = (probe_ff == 2'd0) ? probe_mid : probe_end;
                     end
                  end
               end
            endcase
         end
         S_MODIFY: begin
            case (op_ff)
               OP_ADD: begin
                  // skip, not saturate, when the sum would pass the cap
                  if (sum <= cap_eff) begin
                     mem_req.wr_en = 1'b1;
                     mem_req.wdata = COUNT_WIDTH'(sum);
                  end
                  ptr_in    = ptr_ff + 1'b1;
                  remain_in = remain_ff - 1'b1;
                  state_in  = S_READ;
               end
               OP_READ: begin
                  count_in = RCOUNT_W'(rdata);
                  state_in = S_DONE;
               end
               default: begin
                  if (SUM_W'(rdata) < cap_eff) begin
                     all_in = 1'b0;
                  end
                  if (probe_ff == 2'd2) begin
                     state_in = S_DONE;
                  end else begin
                     probe_in = probe_ff + 1'b1;
                     ptr_in   = (probe_ff == 2'd0) ? probe_mid : probe_end;
                     state_in = S_READ;
                  end
               end
            endcase
         end
         default: begin
            // hold the result until the output register frees up
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_toxic_in = (op_ff == OP_TOXIC) && all_ff;
               rsp_oor_in   = oor_ff;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      kind_ff      <= kind_in;
      span_ff      <= span_in;
      amount_ff    <= amount_in;
      ptr_ff       <= ptr_in;
      remain_ff    <= remain_in;
      probe_ff     <= probe_in;
      oor_ff       <= oor_in;
      all_ff       <= all_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
      rsp_toxic_ff <= rsp_toxic_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.count        = rsp_count_ff;
   assign rsp_bus.toxic        = rsp_toxic_ff;
   assign rsp_bus.out_of_range = rsp_oor_ff;

   a_no_take_while_clearing : assert property (@(posedge clock) disable iff (reset)
      req_take |-> !clr_busy)
      else $error("word taken during table clear");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside completion");

   a_write_source : assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> ((state_ff == S_MODIFY) && (op_ff == OP_ADD)) ||
                        ((state_ff == S_READ) && (op_ff == OP_SET)))
      else $error("table write from unexpected step");

   a_read_then_modify : assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |=> (state_ff == S_MODIFY))
      else $error("read data not consumed next cycle");

endmodule

// ===== sv/ccct_store.sv =====
module ccct_store (
   input  logic                             clock,
   input  logic                             reset,
   input  ccct_pkg::mem_req_type            mem_req,
   output logic [ccct_pkg::COUNT_WIDTH-1:0] rdata_ff,
   output logic                             busy
);
   import ccct_pkg::*;

   logic [COUNT_WIDTH-1:0] mem [DEPTH];

   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   assign busy = clr_busy_ff;

   // sweep zeros through every entry after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rdata_ff <= mem[mem_req.addr];
      end
   end

endmodule

// ===== dv/tb_capped_coverage_count_table.sv =====
`timescale 1ns / 100ps

module tb_capped_coverage_count_table;
   import ccct_pkg::*;

   localparam int RESET_CYCLES    = 7;
   localparam int WATCHDOG_LIMIT  = 60000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int RANDOM_PHASES   = 7;
   localparam int WORDS_PER_PHASE = 140;
   localparam int HOT_WINDOW      = 16;

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [POSITION_W-1:0] position;
      logic [KIND_W-1:0]     kind;
      logic [SPAN_W-1:0]     span;
      logic [AMOUNT_W-1:0]   amount;
   } cov_word_type;

   typedef struct packed {
      logic [RCOUNT_W-1:0] count;
      logic                toxic;
      logic                out_of_range;
   } cov_result_type;

   logic clock;
   logic reset;

   ccct_req_if req_bus ();
   ccct_rsp_if rsp_bus ();
   ccct_csr_if csr_bus ();

   capped_coverage_count_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   cov_word_type           req_backlog [$];
   cov_result_type         rsp_due_q [$];
   logic [COUNT_WIDTH-1:0] count_table [DEPTH];
   logic [CAP_W-1:0]       cap_shadow;
   logic                   steady;
   int                     error_count;
   cov_word_type           word_in_flight;
   int                     req_gap;
   int                     rsp_stall;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic cov_result_type count_table_step(cov_word_type w);
      cov_result_type   r;
      logic [SUM_W-1:0] lim;
      logic [SUM_W-1:0] sum;
      int unsigned      p;
      int unsigned      idx;
      int unsigned      probe [3];
      logic             all_capped;
      r   = '0;
      lim = (SUM_W'(cap_shadow) < COUNT_MAX) ? SUM_W'(cap_shadow) : COUNT_MAX;
      if (int'(w.kind) >= KINDS) begin
         r.out_of_range = 1'b1;
         return r;
      end
      case (w.op)
         OP_ADD: begin
            for (int i = 0; i < int'(w.span); i++) begin
               p = int'(w.position) + i;
               if (p >= POSITIONS) begin
                  r.out_of_range = 1'b1;
               end else begin
                  idx = p * KINDS + w.kind;
                  sum = SUM_W'(count_table[idx]) + SUM_W'(w.amount);
                  // skip, never saturate
                  if (sum <= lim) count_table[idx] = sum[COUNT_WIDTH-1:0];
               end
            end
         end
         OP_SET: begin
            idx = int'(w.position) * KINDS + w.kind;
            if (int'(w.position) >= POSITIONS) r.out_of_range = 1'b1;
            else if (SUM_W'(w.amount) <= lim) count_table[idx] = w.amount[COUNT_WIDTH-1:0];
         end
         OP_READ: begin
            idx = int'(w.position) * KINDS + w.kind;
            if (int'(w.position) >= POSITIONS) r.out_of_range = 1'b1;
            else r.count = RCOUNT_W'(count_table[idx]);
         end
         OP_TOXIC: begin
            probe[0]   = 32'(w.position);
            probe[1]   = int'(w.position) + int'(w.span) / 2;
            probe[2]   = int'(w.position) + int'(w.span);
            all_capped = 1'b1;
            for (int k = 0; k < 3; k++) begin
               if (probe[k] >= POSITIONS) begin
                  r.out_of_range = 1'b1;
                  all_capped     = 1'b0;
               end else if (SUM_W'(count_table[probe[k] * KINDS + w.kind]) < lim) begin
                  all_capped = 1'b0;
               end
            end
            r.toxic = all_capped;
         end
      endcase
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            rsp_due_q.push_back(count_table_step(word_in_flight));
            req_gap = pick_gap();
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               word_in_flight = req_backlog.pop_front();
               req_bus.op       <= word_in_flight.op;
               req_bus.position <= word_in_flight.position;
               req_bus.kind     <= word_in_flight.kind;
               req_bus.span     <= word_in_flight.span;
               req_bus.amount   <= word_in_flight.amount;
               req_bus.valid    <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      cov_result_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_due_q.size() == 0) begin
               $error("response word with nothing outstanding");
               error_count++;
            end else begin
               due = rsp_due_q.pop_front();
               if (rsp_bus.count !== due.count) begin
                  $error("count: expected %0d, got %0d", due.count, rsp_bus.count);
                  error_count++;
               end
               if (rsp_bus.toxic !== due.toxic) begin
                  $error("toxic: expected %0d, got %0d", due.toxic, rsp_bus.toxic);
                  error_count++;
               end
               if (rsp_bus.out_of_range !== due.out_of_range) begin
                  $error("out_of_range: expected %0d, got %0d",
                         due.out_of_range, rsp_bus.out_of_range);
                  error_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_stall = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb_capped_coverage_count_table: done, errors");
      $finish;
   end

   task automatic queue_word(input logic [OP_W-1:0] op, input int pos, input int kind,
                             input int span, input int amount);
      cov_word_type w;
      w.op       = op;
      w.position = POSITION_W'(pos);
      w.kind     = KIND_W'(kind);
      w.span     = SPAN_W'(span);
      w.amount   = AMOUNT_W'(amount);
      req_backlog.push_back(w);
   endtask

   task automatic queue_random_word(input int hot_base, input int hot_kind);
      int               r;
      int               pos;
      int               kind;
      int               span;
      logic [OP_W-1:0]  op;
      logic [CAP_W-1:0] amt;
      r  = $urandom_range(0, 99);
      op = (r < 35) ? OP_ADD : (r < 55) ? OP_SET : (r < 80) ? OP_READ : OP_TOXIC;
      // keep most traffic in a small window so entries climb to the cap
      if ($urandom_range(0, 99) < 70)
         pos = (hot_base + $urandom_range(0, HOT_WINDOW - 1)) % POSITIONS;
      else pos = $urandom_range(0, POSITIONS - 1);
      kind = ($urandom_range(0, 99) < 60) ? hot_kind : $urandom_range(0, KINDS - 1);
      r = $urandom_range(0, 99);
      if (r < 75) span = $urandom_range(0, 8);
      else if (r < 95) span = $urandom_range(9, 64);
      else if (r < 99) span = $urandom_range(65, POSITIONS - 1);
      else span = POSITIONS;
      r = $urandom_range(0, 99);
      if (r < 25) amt = CAP_W'($urandom_range(0, 2));
      else if (r < 45) amt = cap_shadow;
      else if (r < 55) amt = cap_shadow + 1'b1;
      else if (r < 70) amt = cap_shadow - CAP_W'($urandom_range(0, 3));
      else amt = CAP_W'($urandom);
      queue_word(op, pos, kind, span, int'(amt));
   endtask

   // hold the sender until every response is back, then let the block settle
   task automatic drain();
      while (req_backlog.size() != 0 || req_bus.valid || rsp_due_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_cap(input logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      cap_shadow = value;
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      int cap_plan [RANDOM_PHASES];
      int hot_base;
      int hot_kind;
      error_count = 0;
      steady      = 1'b0;
      cap_shadow  = 16'hFFFF;
      foreach (count_table[i]) count_table[i] = '0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.op       = OP_ADD;
      req_bus.position = '0;
      req_bus.kind     = '0;
      req_bus.span     = '0;
      req_bus.amount   = '0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.data     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed, cap at its reset value
      queue_word(OP_ADD,   0,    0, 0,    5);
      queue_word(OP_READ,  0,    0, 0,    0);
      queue_word(OP_ADD,   0,    0, 1,    5);
      queue_word(OP_READ,  0,    0, 0,    0);
      queue_word(OP_ADD,   0,    1, 4096, 1);
      queue_word(OP_READ,  4095, 1, 0,    0);
      queue_word(OP_ADD,   4090, 2, 10,   65535);
      queue_word(OP_ADD,   4095, 2, 1,    1);
      queue_word(OP_READ,  4095, 2, 0,    0);
      queue_word(OP_TOXIC, 4090, 2, 4,    0);
      queue_word(OP_TOXIC, 4090, 2, 6,    0);
      queue_word(OP_TOXIC, 4095, 3, 4096, 0);
      queue_word(OP_SET,   4095, 3, 0,    65535);
      queue_word(OP_TOXIC, 4095, 3, 0,    0);
      queue_word(OP_SET,   0,    3, 0,    0);
      queue_word(OP_ADD,   2048, 3, 4095, 16'hAAAA);
      queue_word(OP_SET,   2049, 3, 8191, 16'h5555);
      queue_word(OP_READ,  2049, 3, 0,    0);
      queue_word(OP_ADD,   4095, 0, 4096, 3);
      drain();

      // zero cap: everything in the table counts as capped
      write_cap(16'h0000);
      queue_word(OP_TOXIC, 100,  0, 8, 0);
      queue_word(OP_SET,   100,  0, 0, 1);
      queue_word(OP_ADD,   0,    0, 2, 0);
      queue_word(OP_SET,   0,    0, 0, 0);
      queue_word(OP_READ,  0,    0, 0, 0);
      queue_word(OP_TOXIC, 4095, 0, 1, 0);
      drain();

      cap_plan = '{3, 1, $urandom_range(0, 65535), 65535, 0, 12, 65534};
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_cap(CAP_W'(cap_plan[ph]));
         steady   = (ph % 3 == 1);
         hot_base = ($urandom_range(0, 3) == 0) ? POSITIONS - 8 : $urandom_range(0, POSITIONS - 1);
         hot_kind = $urandom_range(0, KINDS - 1);
         repeat (WORDS_PER_PHASE) queue_random_word(hot_base, hot_kind);
         drain();
      end

      if (error_count == 0)
         $display("tb_capped_coverage_count_table: done, clean");
      else
         $display("tb_capped_coverage_count_table: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ccct_pkg.sv
sv/ccct_if.sv
sv/ccct_store.sv
sv/capped_coverage_count_table.sv
dv/tb_capped_coverage_count_table.sv
